// ----- rtl/core/qssd_pkg.sv -----
`default_nettype none

package qssd_pkg;

   localparam int MaxResults   = 4;
   localparam int CsrAddrWidth = 3;

   localparam logic [7:0] CharPlus  = 8'h2B;
   localparam logic [7:0] CharPct   = 8'h25;
   localparam logic [7:0] CharAmp   = 8'h26;
   localparam logic [7:0] CharEq    = 8'h3D;
   localparam logic [7:0] CharSpace = 8'h20;

   localparam logic [1:0] KindKey   = 2'd0;
   localparam logic [1:0] KindValue = 2'd1;
   localparam logic [1:0] KindEnd   = 2'd2;

   localparam logic [15:0] LimitReset = 16'd1023;
   localparam logic        RegLimit   = 1'b0;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic [1:0] item_kind;
      logic       query_done;
   } rsp_type;

   typedef struct packed {
      logic [2:0]                  count;
      rsp_type [MaxResults-1:0]    items;
   } batch_type;

   function automatic logic [4:0] hex_value(input logic [7:0] c);
      logic [4:0] v;
      v = 5'd16;
      if (c >= 8'h30 && c <= 8'h39) begin
         v = 5'(c - 8'h30);
      end else if (c >= 8'h61 && c <= 8'h66) begin
         v = 5'(c - 8'h61) + 5'd10;
      end else if (c >= 8'h41 && c <= 8'h46) begin
         v = 5'(c - 8'h41) + 5'd10;
      end
      return v;
   endfunction

   function automatic batch_type push(input batch_type b, input logic [7:0] d,
                                      input logic [1:0] k);
      batch_type r;
      r = b;
      if (b.count < 3'(MaxResults)) begin
         r.items[b.count[1:0]] = '{data_byte: d, item_kind: k, query_done: 1'b0};
         r.count = b.count + 3'd1;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/core/qssd_decode.sv -----
`default_nettype none

module qssd_decode import qssd_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire req_type    item_i,
   input  wire logic       move_i,
   input  wire logic [15:0] limit_i,
   output batch_type      batch_o
);

   logic [1:0]       pend_count_ff, pend_count_in;
   logic [1:0][7:0]  pend_bytes_ff, pend_bytes_in;
   logic             in_value_ff, in_value_in;
   logic             pair_open_ff, pair_open_in;
   logic [15:0]      taken_ff, taken_in;

   logic [7:0]  c;
   logic [4:0]  v;
   logic [7:0]  h;
   logic [4:0]  hv;
   logic [1:0]  kind;
   logic        do_fresh;
   batch_type   b;

   always_comb begin
      c             = item_i.in_byte;
      v             = hex_value(c);
      h             = pend_bytes_ff[1];
      hv            = hex_value(h);
      b             = '0;
      do_fresh      = 1'b0;
      pend_count_in = pend_count_ff;
      pend_bytes_in = pend_bytes_ff;
      in_value_in   = in_value_ff;
      pair_open_in  = pair_open_ff;
      taken_in      = taken_ff;
      kind          = in_value_ff ? KindValue : KindKey;

      if (taken_ff < limit_i) begin
         taken_in = taken_ff + 16'd1;
         if (c == CharAmp) begin
            if (pend_count_in != 2'd0) b = push(b, pend_bytes_in[0], kind);
            if (pend_count_in == 2'd2) b = push(b, pend_bytes_in[1], kind);
            pend_count_in = 2'd0;
            if (pair_open_in) b = push(b, 8'd0, KindEnd);
            pair_open_in = 1'b0;
            in_value_in  = 1'b0;
         end else if (c == CharEq && !in_value_in) begin
            pair_open_in = 1'b1;
            if (pend_count_in != 2'd0) b = push(b, pend_bytes_in[0], kind);
            if (pend_count_in == 2'd2) b = push(b, pend_bytes_in[1], kind);
            pend_count_in = 2'd0;
            in_value_in   = 1'b1;
         end else begin
            pair_open_in = 1'b1;
            if (pend_count_ff == 2'd0) begin
               do_fresh = 1'b1;
            end else if (pend_count_ff == 2'd1) begin
               if (v < 5'd16) begin
                  pend_bytes_in[1] = c;
                  pend_count_in    = 2'd2;
               end else begin
                  pend_count_in = 2'd0;
                  b             = push(b, CharPct, kind);
                  do_fresh      = 1'b1;
               end
            end else begin
               pend_count_in = 2'd0;
               if (v < 5'd16) begin
                  b = push(b, {hv[3:0], v[3:0]}, kind);
               end else begin
                  b        = push(b, CharPct, kind);
                  b        = push(b, h, kind);
                  do_fresh = 1'b1;
               end
            end
            if (do_fresh) begin
               if (c == CharPct) begin
                  pend_bytes_in[0] = c;
                  pend_count_in    = 2'd1;
               end else if (c == CharPlus) begin
                  b = push(b, CharSpace, kind);
               end else begin
                  b = push(b, c, kind);
               end
            end
         end
      end

      if (item_i.in_last) begin
         kind = in_value_in ? KindValue : KindKey;
         if (pend_count_in != 2'd0) b = push(b, pend_bytes_in[0], kind);
         if (pend_count_in == 2'd2) b = push(b, pend_bytes_in[1], kind);
         if (pair_open_in) b = push(b, 8'd0, KindEnd);
         pend_count_in = 2'd0;
         pend_bytes_in = '0;
         pair_open_in  = 1'b0;
         in_value_in   = 1'b0;
         taken_in      = 16'd0;
         if (b.count != 3'd0) begin
            b.items[b.count[1:0] - 2'd1].query_done = 1'b1;
         end
      end
   end

   assign batch_o = b;

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_count_ff <= 2'd0;
         pend_bytes_ff <= '0;
         in_value_ff   <= 1'b0;
         pair_open_ff  <= 1'b0;
         taken_ff      <= 16'd0;
      end else if (move_i) begin
         pend_count_ff <= pend_count_in;
         pend_bytes_ff <= pend_bytes_in;
         in_value_ff   <= in_value_in;
         pair_open_ff  <= pair_open_in;
         taken_ff      <= taken_in;
      end
   end

`ifndef ASSERT_OFF
   a_pend_range: assert property (@(posedge clock) disable iff (reset)
      pend_count_ff != 2'd3)
      else $error("escape hold count out of range");
   a_pend_pct: assert property (@(posedge clock) disable iff (reset)
      pend_count_ff != 2'd0 |-> pend_bytes_ff[0] == CharPct)
      else $error("held escape does not start with percent");
   a_taken_limit: assert property (@(posedge clock) disable iff (reset)
      $stable(limit_i) && move_i && taken_ff >= limit_i && !item_i.in_last
      |=> $stable(taken_ff))
      else $error("byte count advanced past limit");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/qssd_out.sv -----
`default_nettype none

module qssd_out import qssd_pkg::*; (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire batch_type batch_i,
   input  wire logic      load_i,
   output logic           free_o,
   output logic           rsp_valid,
   input  wire logic      rsp_stall,
   output rsp_type        rsp_data
);

   rsp_type [MaxResults-1:0] items_ff;
   logic [2:0]               cnt_ff;
   logic [1:0]               idx_ff;
   logic                     pop;
   logic                     last_pop;

   assign rsp_valid = cnt_ff != 3'd0;
   assign rsp_data  = items_ff[idx_ff];
   assign pop       = rsp_valid && !rsp_stall;
   assign last_pop  = pop && ({1'b0, idx_ff} + 3'd1 == cnt_ff);
   assign free_o    = !rsp_valid || last_pop;

   always_ff @(posedge clock) begin
      if (load_i) begin
         items_ff <= batch_i.items;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 3'd0;
         idx_ff <= 2'd0;
      end else if (load_i) begin
         cnt_ff <= batch_i.count;
         idx_ff <= 2'd0;
      end else if (last_pop) begin
         cnt_ff <= 3'd0;
         idx_ff <= 2'd0;
      end else if (pop) begin
         idx_ff <= idx_ff + 2'd1;
      end
   end

`ifndef ASSERT_OFF
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 3'(MaxResults))
      else $error("result count out of range");
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> {1'b0, idx_ff} < cnt_ff)
      else $error("result index past count");
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      load_i |-> free_o)
      else $error("load while results remain");
   a_advance: assert property (@(posedge clock) disable iff (reset)
      pop && !last_pop && !load_i |=> rsp_valid && idx_ff == $past(idx_ff) + 2'd1)
      else $error("result index did not advance");
   a_done_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.query_done |-> {1'b0, idx_ff} + 3'd1 == cnt_ff)
      else $error("query end flag not on final beat of batch");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/query_string_split_decode.sv -----
// An accepted byte waits in the input register until the output batch register is free.
// Throughput: one byte per cycle while rsp_stall is low and each byte yields at most one beat;
// a byte yielding several beats (end of pair, broken escape) holds input while they drain.
// The output batch register drains one beat per cycle while rsp_stall is low and bounds the rate.
// Reset (synchronous, active high) clears the decode state and sets the byte limit to 1023.
`default_nettype none

module query_string_split_decode import qssd_pkg::*; (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire req_type                 req_data,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output rsp_type                      rsp_data,
   input  wire logic                    psel,
   input  wire logic                    penable,
   input  wire logic                    pwrite,
   input  wire logic [CsrAddrWidth-1:0] paddr,
   input  wire logic [31:0]             pwdata,
   output logic [31:0]                  prdata,
   output logic                         pready
);

   req_type     item_ff;
   logic        full_ff, full_in;
   logic [15:0] limit_ff;
   logic        accept;
   logic        move;
   logic        out_free;
   batch_type   batch;

   assign move      = full_ff && out_free;
   assign req_stall = full_ff && !out_free;
   assign accept    = req_valid && !req_stall;
   assign full_in   = accept ? 1'b1 : (move ? 1'b0 : full_ff);

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff <= 1'b0;
      end else begin
         full_ff <= full_in;
      end
   end

   assign pready = 1'b1;
   assign prdata = (paddr[CsrAddrWidth-1] == RegLimit) ? {16'd0, limit_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LimitReset;
      end else if (psel && penable && pwrite && pready
                   && paddr[CsrAddrWidth-1] == RegLimit) begin
         limit_ff <= pwdata[15:0];
      end
   end

   qssd_decode u_decode (
      .clock   (clock),
      .reset   (reset),
      .item_i  (item_ff),
      .move_i  (move),
      .limit_i (limit_ff),
      .batch_o (batch)
   );

   qssd_out u_out (
      .clock     (clock),
      .reset     (reset),
      .batch_i   (batch),
      .load_i    (move),
      .free_o    (out_free),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// ----- tb/sv/query_string_split_decode_tb.sv -----
`timescale 1ns / 100ps

module query_string_split_decode_tb;
   import qssd_pkg::*;

   localparam logic [CsrAddrWidth-1:0] AddrLimit  = CsrAddrWidth'(4 * RegLimit);
   localparam logic [CsrAddrWidth-1:0] AddrUnused = CsrAddrWidth'(4);

   logic                    clock;
   logic                    reset     = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   req_type                 req_data  = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   rsp_type                 rsp_data;
   logic                    psel      = 1'b0;
   logic                    penable   = 1'b0;
   logic                    pwrite    = 1'b0;
   logic [CsrAddrWidth-1:0] paddr     = '0;
   logic [31:0]             pwdata    = '0;
   logic [31:0]             prdata;
   logic                    pready;

   query_string_split_decode dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   typedef struct {
      req_type beat_in;
      int      n;
      rsp_type want [4];
   } dir_row_type;

   // decoder shadow state
   logic [15:0] limit_q = LimitReset;
   logic [1:0]  esc_cnt = '0;
   logic [7:0]  esc_b0  = '0;
   logic [7:0]  esc_b1  = '0;
   logic        in_val  = 1'b0;
   logic        pair_live = 1'b0;
   logic [15:0] taken_cnt = '0;
   rsp_type     beat_buf [4];
   int          beat_n;

   rsp_type     want_beats [$];
   logic [7:0]  query_bytes [$];
   dir_row_type dir_rows [$];
   int          bad_count = 0;
   int          idle_odds = 0;
   int          stall_left = 0;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("end of test: mismatches");
      $finish;
   end

   function automatic bit hex_ok(logic [7:0] c);
      return c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]};
   endfunction

   function automatic logic [3:0] hex_nib(logic [7:0] c);
      return (c <= 8'h39) ? c[3:0] : c[3:0] + 4'd9;
   endfunction

   function automatic logic [1:0] kind_now();
      return in_val ? KindValue : KindKey;
   endfunction

   function automatic rsp_type bt(logic [7:0] d, logic [1:0] k, logic q);
      rsp_type r;
      r.data_byte  = d;
      r.item_kind  = k;
      r.query_done = q;
      return r;
   endfunction

   task automatic put_beat(logic [7:0] d, logic [1:0] k);
      if (beat_n < MaxResults) begin
         beat_buf[beat_n] = bt(d, k, 1'b0);
         beat_n++;
      end
   endtask

   task automatic plain_byte(logic [7:0] c);
      if (c == CharPct) begin
         esc_b0  = c;
         esc_cnt = 2'd1;
      end else if (c == CharPlus) begin
         put_beat(CharSpace, kind_now());
      end else begin
         put_beat(c, kind_now());
      end
   endtask

   task automatic release_esc();
      if (esc_cnt >= 2'd1) put_beat(esc_b0, kind_now());
      if (esc_cnt == 2'd2) put_beat(esc_b1, kind_now());
      esc_cnt = '0;
   endtask

   task automatic body_byte(logic [7:0] c);
      pair_live = 1'b1;
      case (esc_cnt)
         2'd0: begin
            plain_byte(c);
         end
         2'd1: begin
            if (hex_ok(c)) begin
               esc_b1  = c;
               esc_cnt = 2'd2;
            end else begin
               esc_cnt = '0;
               put_beat(CharPct, kind_now());
               plain_byte(c);
            end
         end
         default: begin
            esc_cnt = '0;
            if (hex_ok(c)) begin
               put_beat({hex_nib(esc_b1), hex_nib(c)}, kind_now());
            end else begin
               put_beat(CharPct, kind_now());
               plain_byte(esc_b1);
               plain_byte(c);
            end
         end
      endcase
   endtask

   task automatic decode_byte(req_type r);
      beat_n = 0;
      if (taken_cnt < limit_q) begin
         taken_cnt++;
         if (r.in_byte == CharAmp) begin
            release_esc();
            if (pair_live) put_beat(8'h00, KindEnd);
            pair_live = 1'b0;
            in_val    = 1'b0;
         end else if (r.in_byte == CharEq && !in_val) begin
            pair_live = 1'b1;
            release_esc();
            in_val = 1'b1;
         end else begin
            body_byte(r.in_byte);
         end
      end
      if (r.in_last) begin
         release_esc();
         if (pair_live) put_beat(8'h00, KindEnd);
         pair_live = 1'b0;
         in_val    = 1'b0;
         esc_b0    = '0;
         esc_b1    = '0;
         taken_cnt = '0;
         if (beat_n > 0) beat_buf[beat_n-1].query_done = 1'b1;
      end
   endtask

   task automatic push_predicted();
      for (int i = 0; i < beat_n; i++) want_beats.push_back(beat_buf[i]);
   endtask

   task automatic add_row(logic [7:0] b, logic l, int n, rsp_type r0 = '0,
                          rsp_type r1 = '0, rsp_type r2 = '0, rsp_type r3 = '0);
      dir_row_type row;
      row.beat_in.in_byte = b;
      row.beat_in.in_last = l;
      row.n       = n;
      row.want[0] = r0;
      row.want[1] = r1;
      row.want[2] = r2;
      row.want[3] = r3;
      dir_rows.push_back(row);
   endtask

   function automatic logic [7:0] pick_alnum();
      int r;
      r = $urandom_range(0, 61);
      if (r < 10) return 8'(8'h30 + r);
      if (r < 36) return 8'(8'h61 + r - 10);
      return 8'(8'h41 + r - 36);
   endfunction

   function automatic logic [7:0] pick_hex();
      int r;
      r = $urandom_range(0, 21);
      if (r < 10) return 8'(8'h30 + r);
      if (r < 16) return 8'(8'h61 + r - 10);
      return 8'(8'h41 + r - 16);
   endfunction

   function automatic logic [7:0] pick_nonhex();
      logic [7:0] c;
      do c = 8'($urandom); while (hex_ok(c));
      return c;
   endfunction

   task automatic add_token();
      case ($urandom_range(0, 15))
         8: query_bytes.push_back(CharPlus);
         9, 10: begin
            query_bytes.push_back(CharPct);
            query_bytes.push_back(pick_hex());
            query_bytes.push_back(pick_hex());
         end
         11: begin
            query_bytes.push_back(CharPct);
            if ($urandom_range(0, 1)) query_bytes.push_back(pick_hex());
            query_bytes.push_back(pick_nonhex());
         end
         12: query_bytes.push_back(CharEq);
         13: query_bytes.push_back(8'($urandom));
         14: query_bytes.push_back(CharPct);
         15: query_bytes.push_back(pick_hex());
         default: query_bytes.push_back(pick_alnum());
      endcase
   endtask

   task automatic build_query();
      int np;
      if ($urandom_range(0, 9) == 0) begin
         repeat ($urandom_range(1, 12)) query_bytes.push_back(8'($urandom));
      end else begin
         np = $urandom_range(1, 4);
         if ($urandom_range(0, 7) == 0) query_bytes.push_back(CharAmp);
         for (int p = 0; p < np; p++) begin
            if (p > 0) query_bytes.push_back(CharAmp);
            if ($urandom_range(0, 7) != 0) begin
               repeat ($urandom_range(0, 5)) add_token();
               if ($urandom_range(0, 7) != 0) query_bytes.push_back(CharEq);
               repeat ($urandom_range(0, 6)) add_token();
            end
         end
         if ($urandom_range(0, 7) == 0) query_bytes.push_back(CharAmp);
      end
      if (query_bytes.size() == 0) query_bytes.push_back(CharAmp);
   endtask

   task automatic maybe_gap();
      if (idle_odds > 0 && $urandom_range(1, idle_odds) == 1) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
   endtask

   task automatic send_byte(req_type r);
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      decode_byte(r);
   endtask

   task automatic set_reg(logic [CsrAddrWidth-1:0] addr, logic [31:0] val);
      req_valid <= 1'b0;
      while (want_beats.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= val;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (addr == AddrLimit) limit_q = val[15:0];
   endtask

   task automatic run_phase(int quota, int odds, bit close_query);
      int      done_items;
      req_type r;
      idle_odds  = odds;
      done_items = 0;
      while (done_items < quota || (close_query && query_bytes.size() != 0)) begin
         if (query_bytes.size() == 0) build_query();
         r.in_byte = query_bytes.pop_front();
         r.in_last = (query_bytes.size() == 0);
         maybe_gap();
         send_byte(r);
         push_predicted();
         done_items++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (want_beats.size() == 0) begin
               if (bad_count < 10)
                  $display("unexpected beat: byte %h kind %0d done %0d",
                           rsp_data.data_byte, rsp_data.item_kind, rsp_data.query_done);
               bad_count++;
            end else begin
               want = want_beats.pop_front();
               if (rsp_data.data_byte !== want.data_byte ||
                   rsp_data.item_kind !== want.item_kind ||
                   rsp_data.query_done !== want.query_done) begin
                  if (bad_count < 10)
                     $display("mismatch: want %h/%0d/%0d got %h/%0d/%0d",
                              want.data_byte, want.item_kind, want.query_done,
                              rsp_data.data_byte, rsp_data.item_kind, rsp_data.query_done);
                  bad_count++;
               end
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (idle_odds > 0 && $urandom_range(1, idle_odds) == 1) begin
            stall_left = $urandom_range(0, 15);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      add_row("a", 1'b0, 1, bt("a", KindKey, 1'b0));
      add_row(CharEq, 1'b0, 0);
      add_row(CharPlus, 1'b0, 1, bt(CharSpace, KindValue, 1'b0));
      add_row(CharPct, 1'b0, 0);
      add_row("4", 1'b0, 0);
      add_row("1", 1'b0, -1);
      add_row(CharAmp, 1'b0, 1, bt(8'h00, KindEnd, 1'b0));
      add_row(CharAmp, 1'b0, 0);
      add_row(CharEq, 1'b0, 0);
      add_row(CharPct, 1'b0, 0);
      add_row("g", 1'b0, 2, bt(CharPct, KindValue, 1'b0), bt("g", KindValue, 1'b0));
      add_row(CharPct, 1'b0, 0);
      add_row("F", 1'b0, 0);
      add_row("z", 1'b0, 3, bt(CharPct, KindValue, 1'b0), bt("F", KindValue, 1'b0),
              bt("z", KindValue, 1'b0));
      add_row(CharPct, 1'b1, 2, bt(CharPct, KindValue, 1'b0), bt(8'h00, KindEnd, 1'b1));
      add_row(8'h00, 1'b0, 1, bt(8'h00, KindKey, 1'b0));
      add_row(8'hFF, 1'b0, 1, bt(8'hFF, KindKey, 1'b0));
      add_row(CharPct, 1'b0, 0);
      add_row("a", 1'b0, 0);
      add_row(CharEq, 1'b0, 2, bt(CharPct, KindKey, 1'b0), bt("a", KindKey, 1'b0));
      add_row(CharEq, 1'b0, 1, bt(CharEq, KindValue, 1'b0));
      add_row(CharPct, 1'b0, 0);
      add_row("f", 1'b0, 0);
      add_row("f", 1'b0, -1);
      add_row(CharAmp, 1'b1, 1, bt(8'h00, KindEnd, 1'b1));
      add_row(CharAmp, 1'b1, 0);
      add_row("x", 1'b1, 2, bt("x", KindKey, 1'b0), bt(8'h00, KindEnd, 1'b1));

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      idle_odds = 4;
      foreach (dir_rows[i]) begin
         maybe_gap();
         send_byte(dir_rows[i].beat_in);
         if (dir_rows[i].n < 0) begin
            push_predicted();
         end else begin
            for (int j = 0; j < dir_rows[i].n; j++)
               want_beats.push_back(dir_rows[i].want[j]);
         end
      end

      run_phase(50, 6, 1'b0);
      set_reg(AddrLimit, {16'($urandom), 16'd65535});
      run_phase(50, 4, 1'b0);
      set_reg(AddrLimit, 32'd1);
      run_phase(50, 8, 1'b0);
      set_reg(AddrUnused, $urandom);
      set_reg(AddrLimit, 32'($urandom_range(2, 8)));
      run_phase(50, 3, 1'b0);
      set_reg(AddrLimit, 32'($urandom_range(9, 40)));
      run_phase(50, 6, 1'b0);
      set_reg(AddrLimit, 32'($urandom_range(1, 65535)));
      run_phase(50, 5, 1'b0);
      set_reg(AddrLimit, 32'(LimitReset));
      run_phase(50, 0, 1'b1);

      // drain
      req_valid <= 1'b0;
      while (want_beats.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (bad_count == 0 && want_beats.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
